>>> rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the glyph row expander.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property checked on the rising clock, quiet while reset is low.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never hold on a clock edge out of reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> rtl/grpe_pkg.sv
// Shared types and constants of the glyph row expander.
package grpe_pkg;

  // Command codes of an input item
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_COUNT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_STRIDE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE  = 3'd4;

  // Register widths and reset values
  localparam int unsigned CFG_DATA_W = 17;
  localparam logic [5:0]  RST_GLYPH_WIDTH  = 6'd8;
  localparam logic [5:0]  RST_GLYPH_HEIGHT = 6'd16;
  localparam logic [9:0]  RST_GLYPH_COUNT  = 10'd256;
  localparam logic [7:0]  RST_GLYPH_STRIDE = 8'd16;
  localparam logic [16:0] RST_LINE_STRIDE  = 17'd4096;

  // Datapath widths: font byte address sum, multiplier operand, accumulator, font store write address
  localparam int unsigned BASE_W  = 18;
  localparam int unsigned OPND_W  = 17;
  localparam int unsigned ACC_W   = 2 * OPND_W;
  localparam int unsigned FADDR_W = 13;

  // Font store write port
  typedef struct packed {
    logic               en;
    logic [FADDR_W-1:0] addr;
    logic [7:0]         data;
  } font_wr_t;

  // One multiply-accumulate operation: a * b + c
  typedef struct packed {
    logic [OPND_W-1:0] a;
    logic [OPND_W-1:0] b;
    logic [ACC_W-1:0]  c;
  } mac_op_t;

endpackage

>>> rtl/glyph_row_pixel_expander.sv
// Top level of the glyph row expander: sequencer, registers and pixel output.
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one item per transfer.
//   A load item (cmd 0) writes font_byte_i into the font store at
//   font_addr_i; it produces no output.
//   A draw item (cmd 1) produces glyph_width pixel writes on the output
//   channel (out_valid_o / out_stall_i), leftmost column first, each with
//   its framebuffer byte offset, colour and a last_pixel flag on the final
//   column. A row at or past glyph_height, or a zero width, gives nothing.
//   Five address steps run through one shared multiply-accumulate unit
//   (glyph base, font row, screen line, line offset, column offset) before
//   the first pixel is ready. After that one pixel leaves per cycle while
//   the output is not stalled; the font store is read one byte ahead of
//   the pixel shifter. Input stays stalled while a draw runs.
//   An output stall holds the pixel register and pauses pixel emission.
//   Reset restores the register defaults and empties the output register;
//   font store contents stay undefined until loaded.
//   Configuration writes (cfg_we_i) belong in idle periods only.
`include "assert_macros.svh"

module glyph_row_pixel_expander
  import grpe_pkg::*;
#(
  parameter int unsigned FONT_BYTES      = 8192,
  parameter int unsigned MAX_GLYPH_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  cmd_i,
  input  logic [12:0]           font_addr_i,
  input  logic [7:0]            font_byte_i,
  input  logic [8:0]            char_code_i,
  input  logic [9:0]            cell_col_i,
  input  logic [9:0]            cell_row_i,
  input  logic [4:0]            glyph_row_i,
  input  logic [23:0]           fg_colour_i,
  input  logic [23:0]           bg_colour_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [31:0]           pixel_offset_o,
  output logic [23:0]           pixel_word_o,
  output logic                  last_pixel_o,
  // configuration port
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned XW = $clog2(MAX_GLYPH_WIDTH);
  localparam int unsigned WW = $clog2(MAX_GLYPH_WIDTH + 1);

  // Sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_GLYPH = 3'd1;
  localparam logic [2:0] S_BASE  = 3'd2;
  localparam logic [2:0] S_ROW   = 3'd3;
  localparam logic [2:0] S_LINE  = 3'd4;
  localparam logic [2:0] S_COL   = 3'd5;
  localparam logic [2:0] S_EMIT  = 3'd6;

  logic [2:0]  state_q, state_d;

  // configuration registers
  logic [5:0]  glyph_width_q;
  logic [5:0]  glyph_height_q;
  logic [9:0]  glyph_count_q;
  logic [7:0]  glyph_stride_q;
  logic [16:0] line_stride_q;

  // latched draw item
  logic [8:0]  glyph_q;
  logic [4:0]  grow_q;
  logic [9:0]  crow_q;
  logic [9:0]  ccol_q;
  logic [23:0] fg_q;
  logic [23:0] bg_q;

  // datapath registers
  logic [ACC_W-1:0]  acc_q;
  logic [BASE_W-1:0] addr_q;
  logic [31:0]       off_q;
  logic [7:0]        shift_q;
  logic [XW-1:0]     x_q;

  // output register
  logic        out_valid_q;
  logic [31:0] out_off_q;
  logic [23:0] out_word_q;
  logic        out_last_q;

  logic          in_fire;
  logic          draw_ok;
  logic [WW-1:0] w_eff;
  logic [6:0]    w_plus7;
  logic [2:0]    row_bytes;
  logic          out_free;
  logic          pix_fire;
  logic          pix_last;
  logic [7:0]    rd_data;
  mac_op_t       mac_op;
  logic [ACC_W-1:0] mac_res;
  font_wr_t      font_wr;

  // Effective width, saturated to the widest supported glyph
  assign w_eff = (glyph_width_q > 6'(MAX_GLYPH_WIDTH)) ? WW'(MAX_GLYPH_WIDTH)
                                                       : WW'(glyph_width_q);
  assign w_plus7   = 7'(w_eff) + 7'd7;
  assign row_bytes = w_plus7[5:3];

  assign in_stall_o = (state_q != S_IDLE);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign draw_ok    = (w_eff != '0) && (6'(glyph_row_i) < glyph_height_q);

  assign out_free = !out_valid_q || !out_stall_i;
  assign pix_fire = (state_q == S_EMIT) && out_free;
  assign pix_last = (WW'(x_q) + WW'(1)) == w_eff;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      glyph_width_q  <= RST_GLYPH_WIDTH;
      glyph_height_q <= RST_GLYPH_HEIGHT;
      glyph_count_q  <= RST_GLYPH_COUNT;
      glyph_stride_q <= RST_GLYPH_STRIDE;
      line_stride_q  <= RST_LINE_STRIDE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GLYPH_WIDTH:  glyph_width_q  <= cfg_wdata_i[5:0];
        REG_GLYPH_HEIGHT: glyph_height_q <= cfg_wdata_i[5:0];
        REG_GLYPH_COUNT:  glyph_count_q  <= cfg_wdata_i[9:0];
        REG_GLYPH_STRIDE: glyph_stride_q <= cfg_wdata_i[7:0];
        REG_LINE_STRIDE:  line_stride_q  <= cfg_wdata_i[16:0];
        default: ;
      endcase
    end
  end

  // Font store load path
  assign font_wr.en   = in_fire && (cmd_i == CMD_LOAD);
  assign font_wr.addr = font_addr_i;
  assign font_wr.data = font_byte_i;

  grpe_font #(
    .DEPTH (FONT_BYTES)
  ) u_font (
    .clk_i     (clk_i),
    .wr_i      (font_wr),
    .rd_addr_i (addr_q),
    .rd_data_o (rd_data)
  );

  // Operand selection for the shared multiply-accumulate unit
  always_comb begin
    mac_op = '0;
    case (state_q)
      S_GLYPH: begin
        mac_op.a = OPND_W'(glyph_q);
        mac_op.b = OPND_W'(glyph_stride_q);
      end
      S_BASE: begin
        mac_op.a = OPND_W'(grow_q);
        mac_op.b = OPND_W'(row_bytes);
        mac_op.c = acc_q;
      end
      S_ROW: begin
        mac_op.a = OPND_W'(crow_q);
        mac_op.b = OPND_W'(glyph_height_q);
        mac_op.c = ACC_W'(grow_q);
      end
      S_LINE: begin
        mac_op.a = acc_q[OPND_W-1:0];
        mac_op.b = line_stride_q;
      end
      S_COL: begin
        mac_op.a = OPND_W'(ccol_q);
        mac_op.b = OPND_W'({w_eff, 2'b00});
        mac_op.c = acc_q;
      end
      default: ;
    endcase
  end

  grpe_mac u_mac (
    .op_i  (mac_op),
    .res_o (mac_res)
  );

  // Sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_fire && (cmd_i == CMD_DRAW) && draw_ok) begin
          state_d = S_GLYPH;
        end
      end
      S_GLYPH: state_d = S_BASE;
      S_BASE:  state_d = S_ROW;
      S_ROW:   state_d = S_LINE;
      S_LINE:  state_d = S_COL;
      S_COL:   state_d = S_EMIT;
      S_EMIT: begin
        if (pix_fire && pix_last) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Latch the draw item; codes of zero or past the font use glyph 0
  always_ff @(posedge clk_i) begin
    if (in_fire && (cmd_i == CMD_DRAW)) begin
      glyph_q <= ((char_code_i != 9'd0) && (10'(char_code_i) < glyph_count_q))
                 ? char_code_i : 9'd0;
      grow_q  <= glyph_row_i;
      crow_q  <= cell_row_i;
      ccol_q  <= cell_col_i;
      fg_q    <= fg_colour_i;
      bg_q    <= bg_colour_i;
    end
  end

  // Address steps and pixel shifter
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_GLYPH: acc_q  <= mac_res;
      S_BASE:  addr_q <= mac_res[BASE_W-1:0];
      S_ROW:   acc_q  <= mac_res;
      S_LINE:  acc_q  <= mac_res;
      S_COL: begin
        // font byte at the row base has been read by now
        off_q   <= mac_res[31:0];
        shift_q <= rd_data;
        addr_q  <= addr_q + BASE_W'(1);
        x_q     <= '0;
      end
      S_EMIT: begin
        if (pix_fire) begin
          off_q <= off_q + 32'd4;
          x_q   <= x_q + XW'(1);
          if (x_q[2:0] == 3'b111) begin
            // next byte was fetched while this one shifted out
            shift_q <= rd_data;
            addr_q  <= addr_q + BASE_W'(1);
          end else begin
            shift_q <= {shift_q[6:0], 1'b0};
          end
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pix_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix_fire) begin
      out_off_q  <= off_q;
      out_word_q <= shift_q[7] ? fg_q : bg_q;
      out_last_q <= pix_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_offset_o = out_off_q;
  assign pixel_word_o   = out_word_q;
  assign last_pixel_o   = out_last_q;

  // Checks
  `ASSERT_PROP(a_col_clears_x, (state_q == S_COL) |=> (x_q == '0),
               "pixel column does not restart at zero")
  `ASSERT_PROP(a_x_in_width, (state_q == S_EMIT) |-> (WW'(x_q) < w_eff),
               "pixel column ran past the glyph width")
  `ASSERT_NEVER(a_last_ends_row, pix_fire && pix_last && (state_d != S_IDLE),
                "row still emitting after its last pixel")

endmodule

>>> rtl/grpe_mac.sv
// Shared multiply-accumulate unit used by every address step.
module grpe_mac
  import grpe_pkg::*;
(
  input  mac_op_t          op_i,
  output logic [ACC_W-1:0] res_o
);

  // Unsigned product plus addend, wrapping at the accumulator width
  assign res_o = (ACC_W'(op_i.a) * ACC_W'(op_i.b)) + op_i.c;

endmodule

>>> rtl/grpe_font.sv
// Font byte store with one write port and one registered read port.
module grpe_font
  import grpe_pkg::*;
#(
  parameter int unsigned DEPTH = 8192
) (
  input  logic              clk_i,
  input  font_wr_t          wr_i,
  input  logic [BASE_W-1:0] rd_addr_i,
  output logic [7:0]        rd_data_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [7:0]        mem [DEPTH];
  logic [BASE_W-1:0] wr_addr_ext;
  logic              wr_in_range;
  logic              rd_in_range;
  logic [7:0]        rd_data_q;

  assign wr_addr_ext = BASE_W'(wr_i.addr);
  assign wr_in_range = wr_addr_ext < BASE_W'(DEPTH);
  assign rd_in_range = rd_addr_i < BASE_W'(DEPTH);

  // Writes past the store are dropped
  always_ff @(posedge clk_i) begin
    if (wr_i.en && wr_in_range) begin
      mem[wr_addr_ext[AW-1:0]] <= wr_i.data;
    end
  end

  // Reads past the store return zero
  always_ff @(posedge clk_i) begin
    if (rd_in_range) begin
      rd_data_q <= mem[rd_addr_i[AW-1:0]];
    end else begin
      rd_data_q <= 8'd0;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
